// ===== rtl/core/spring_length_constraint_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spring length constraint block
// Each macro expands to one labeled concurrent assertion on clock / reset.
// ----------------------------------------------------------------------------
`ifndef SPRING_LENGTH_CONSTRAINT_MACROS_SVH
`define SPRING_LENGTH_CONSTRAINT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SLC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SLC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/slc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg
// Shared widths, types and codes of the spring length constraint pipeline.
// ----------------------------------------------------------------------------
package slc_pkg;

   localparam int SLC_FRACTION_BITS = 16;
   localparam int SLC_COORD_W       = 32;
   localparam int SLC_LIM_W         = 31;
   localparam int SLC_MAG_W         = 33;
   localparam int SLC_SUM_W         = 66;
   localparam int SLC_LEN_W         = 33;
   localparam int SLC_SQRT_STEPS    = 33;
   localparam int SLC_REM_W         = 36;
   localparam int SLC_DREM_W        = 34;
   localparam int SLC_KD_W          = 65;
   localparam int SLC_REQ_W         = 320;
   localparam int SLC_RSP_W         = 192;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_STRETCH = 2'd1,
      ACT_SQUEEZE = 2'd2,
      ACT_PULL    = 2'd3
   } action_type;

   typedef struct packed {
      logic [2:0][SLC_COORD_W-1:0] first;
      logic [2:0][SLC_COORD_W-1:0] second;
      logic [2:0][SLC_MAG_W-1:0]   mag;
      logic [2:0]                  neg;
      logic [SLC_COORD_W-1:0]      stiffness;
      logic [SLC_LIM_W-1:0]        rest;
      logic [SLC_LIM_W-1:0]        maxl;
      logic [SLC_LIM_W-1:0]        minl;
   } slc_pay_type;

endpackage

// ===== rtl/core/spring_length_constraint.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle while the skid entry is empty; set by the
// square root chain (33 cells) and the divider chain (FRACTION_BITS + 1 cells),
// both fully pipelined.
// A two-entry output stage keeps taking requests while one result waits.
// Synchronous reset clears valid flags only; no clearing pass is needed.
// ----------------------------------------------------------------------------
// spring_length_constraint
// Cloth spring length clamp and Hooke force, Q16.16 fixed point.
// ----------------------------------------------------------------------------
module spring_length_constraint
   import slc_pkg::*;
#(
   parameter int FRACTION_BITS = SLC_FRACTION_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   // first_x, first_y, first_z, second_x, second_y, second_z, stiffness,
   // rest_length, stretch_limit, squeeze_limit, zero pad
   input  logic [SLC_REQ_W-1:0] req_tdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // new_second_x, new_second_y, new_second_z, pull_x, pull_y, pull_z
   output logic [SLC_RSP_W-1:0] rsp_tdata,
   // action
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready
);

   localparam int QW    = FRACTION_BITS + 1;
   localparam int OFF_W = FRACTION_BITS + 32;
   localparam int PLO_W = 32 + QW;
   localparam int PHI_W = 33 + QW;
   localparam int Q_W   = SLC_KD_W + QW;
   localparam int M_W   = Q_W - 2 * FRACTION_BITS;

   logic en;
   assign en         = !skid_vld_ff;
   assign req_tready = en;

   // ---------------- front: differences, squares, sum ----------------
   slc_pay_type               a_pay_in, a_pay_ff, b_pay_ff, c_pay_ff;
   logic                      a_vld_ff, b_vld_ff, c_vld_ff;
   logic [2:0][SLC_SUM_W-1:0] sq_in, sq_ff;
   logic [SLC_SUM_W-1:0]      sum_in, sum_ff;
   logic [SLC_MAG_W-1:0]      dv;

   always_comb begin
      a_pay_in = '0;
      dv       = '0;
      for (int i = 0; i < 3; i++) begin
         a_pay_in.first[i]  = req_tdata[32*i +: 32];
         a_pay_in.second[i] = req_tdata[96 + 32*i +: 32];
         dv = {a_pay_in.second[i][31], a_pay_in.second[i]}
            - {a_pay_in.first[i][31], a_pay_in.first[i]};
         a_pay_in.neg[i] = dv[SLC_MAG_W-1];
         a_pay_in.mag[i] = dv[SLC_MAG_W-1] ? (~dv + 1'b1) : dv;
      end
      a_pay_in.stiffness = req_tdata[223:192];
      a_pay_in.rest      = req_tdata[254:224];
      a_pay_in.maxl      = req_tdata[285:255];
      a_pay_in.minl      = req_tdata[316:286];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SLC_SUM_W'(a_pay_ff.mag[i]) * SLC_SUM_W'(a_pay_ff.mag[i]);
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_pay_ff <= a_pay_in;
         sq_ff    <= sq_in;
         b_pay_ff <= a_pay_ff;
         sum_ff   <= sum_in;
         c_pay_ff <= b_pay_ff;
      end
   end

   // ---------------- square root chain ----------------
   logic        [SLC_SQRT_STEPS:0]                 s_vld;
   logic        [SLC_SQRT_STEPS:0][SLC_SUM_W-1:0]  s_rad;
   logic        [SLC_SQRT_STEPS:0][SLC_REM_W-1:0]  s_rem;
   logic        [SLC_SQRT_STEPS:0][SLC_LEN_W-1:0]  s_root;
   slc_pay_type [SLC_SQRT_STEPS:0]                 s_pay;

   assign s_vld[0]  = c_vld_ff;
   assign s_rad[0]  = sum_ff;
   assign s_rem[0]  = '0;
   assign s_root[0] = '0;
   assign s_pay[0]  = c_pay_ff;

   for (genvar g = 0; g < SLC_SQRT_STEPS; g++) begin : g_sqrt
      slc_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_vld  (s_vld[g]),
         .up_rad  (s_rad[g]),
         .up_rem  (s_rem[g]),
         .up_root (s_root[g]),
         .up_pay  (s_pay[g]),
         .dn_vld  (s_vld[g+1]),
         .dn_rad  (s_rad[g+1]),
         .dn_rem  (s_rem[g+1]),
         .dn_root (s_root[g+1]),
         .dn_pay  (s_pay[g+1])
      );
   end

   // ---------------- divider chain ----------------
   logic        [QW:0]                       d_vld;
   logic        [QW:0][2:0][SLC_DREM_W-1:0]  d_rem;
   logic        [QW:0][2:0][QW-1:0]          d_quo;
   logic        [QW:0][SLC_LEN_W-1:0]        d_len;
   slc_pay_type [QW:0]                       d_pay;

   assign d_vld[0] = s_vld[SLC_SQRT_STEPS];
   assign d_len[0] = s_root[SLC_SQRT_STEPS];
   assign d_pay[0] = s_pay[SLC_SQRT_STEPS];
   assign d_quo[0] = '0;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_rem[0][i] = {1'b0, s_pay[SLC_SQRT_STEPS].mag[i]};
      end
   end

   for (genvar g = 0; g < QW; g++) begin : g_div
      slc_div_cell #(
         .QW (QW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .up_vld (d_vld[g]),
         .up_rem (d_rem[g]),
         .up_quo (d_quo[g]),
         .up_len (d_len[g]),
         .up_pay (d_pay[g]),
         .dn_vld (d_vld[g+1]),
         .dn_rem (d_rem[g+1]),
         .dn_quo (d_quo[g+1]),
         .dn_len (d_len[g+1]),
         .dn_pay (d_pay[g+1])
      );
   end

   // ---------------- back end: decision, products, saturation ----------------
   slc_pay_type          dp;
   logic [SLC_LEN_W-1:0] dlen;
   logic [2:0][QW-1:0]   ulen;
   action_type           act_in;
   logic [SLC_LIM_W-1:0] lim;
   logic [SLC_LEN_W-1:0] over;

   logic                          m1_vld_ff, m2_vld_ff, m3_vld_ff;
   action_type                    m1_act_ff, m2_act_ff, m3_act_ff;
   logic [2:0][OFF_W-1:0]         off_in, off_ff;
   logic [SLC_KD_W-1:0]           kd_in, kd_ff;
   logic [2:0][QW-1:0]            ulen_ff;
   logic [2:0]                    m1_neg_ff, m2_neg_ff, m3_neg_ff;
   logic [2:0][31:0]              m1_first_ff;
   logic [2:0][31:0]              m1_second_ff, m2_second_ff, m3_second_ff;
   logic [2:0][31:0]              res_in, res_ff, m3_res_ff;
   logic [2:0][PLO_W-1:0]         plo_in, plo_ff;
   logic [2:0][PHI_W-1:0]         phi_in, phi_ff;
   logic [2:0][M_W-1:0]           mag_in, mag_ff;
   logic [33:0]                   s34, f34, o34;
   logic [Q_W-1:0]                qsum;

   assign dp   = d_pay[QW];
   assign dlen = d_len[QW];
   assign over = dlen - {2'b00, dp.rest};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ulen[i] = (dlen == '0) ? '0 : d_quo[QW][i];
      end
      priority if (dlen > {2'b00, dp.maxl}) begin
         act_in = ACT_STRETCH;
         lim    = dp.maxl;
      end else if (dlen < {2'b00, dp.minl}) begin
         act_in = ACT_SQUEEZE;
         lim    = dp.minl;
      end else if (dlen > {2'b00, dp.rest}) begin
         act_in = ACT_PULL;
         lim    = dp.minl;
      end else begin
         act_in = ACT_NONE;
         lim    = dp.minl;
      end
      for (int i = 0; i < 3; i++) begin
         off_in[i] = OFF_W'(ulen[i]) * OFF_W'(lim);
      end
      kd_in = SLC_KD_W'(dp.stiffness) * SLC_KD_W'(over);
   end

   // clamp position and force partial products
   always_comb begin
      s34 = '0;
      f34 = '0;
      o34 = '0;
      for (int i = 0; i < 3; i++) begin
         f34 = {{2{m1_first_ff[i][31]}}, m1_first_ff[i]};
         o34 = {2'b00, off_ff[i][FRACTION_BITS +: 32]};
         s34 = m1_neg_ff[i] ? (f34 - o34) : (f34 + o34);
         if (!s34[33] && (s34[32] || s34[31])) begin
            res_in[i] = 32'h7FFF_FFFF;
         end else if (s34[33] && !(s34[32] && s34[31])) begin
            res_in[i] = 32'h8000_0000;
         end else begin
            res_in[i] = s34[31:0];
         end
         plo_in[i] = PLO_W'(kd_ff[31:0]) * PLO_W'(ulen_ff[i]);
         phi_in[i] = PHI_W'(kd_ff[SLC_KD_W-1:32]) * PHI_W'(ulen_ff[i]);
      end
   end

   always_comb begin
      qsum = '0;
      for (int i = 0; i < 3; i++) begin
         qsum      = (Q_W'(phi_ff[i]) << 32) + Q_W'(plo_ff[i]);
         mag_in[i] = qsum[Q_W-1:2*FRACTION_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
      end else if (en) begin
         m1_vld_ff <= d_vld[QW];
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_act_ff    <= act_in;
         off_ff       <= off_in;
         kd_ff        <= kd_in;
         ulen_ff      <= ulen;
         m1_neg_ff    <= dp.neg;
         m1_first_ff  <= dp.first;
         m1_second_ff <= dp.second;

         m2_act_ff    <= m1_act_ff;
         res_ff       <= res_in;
         plo_ff       <= plo_in;
         phi_ff       <= phi_in;
         m2_neg_ff    <= m1_neg_ff;
         m2_second_ff <= m1_second_ff;

         m3_act_ff    <= m2_act_ff;
         mag_ff       <= mag_in;
         m3_res_ff    <= res_ff;
         m3_neg_ff    <= m2_neg_ff;
         m3_second_ff <= m2_second_ff;
      end
   end

   // final saturation and selection
   logic [SLC_RSP_W-1:0] push_data;
   logic [M_W-1:0]       plim, pm;
   logic [31:0]          pval;

   always_comb begin
      push_data = '0;
      plim      = '0;
      pm        = '0;
      pval      = '0;
      for (int i = 0; i < 3; i++) begin
         plim = m3_neg_ff[i] ? M_W'(32'h8000_0000) : M_W'(32'h7FFF_FFFF);
         pm   = (mag_ff[i] > plim) ? plim : mag_ff[i];
         pval = m3_neg_ff[i] ? 32'(~pm + 1'b1) : pm[31:0];
         unique case (m3_act_ff)
            ACT_STRETCH, ACT_SQUEEZE: begin
               push_data[32*i +: 32]      = m3_res_ff[i];
               push_data[96 + 32*i +: 32] = '0;
            end
            ACT_PULL: begin
               push_data[32*i +: 32]      = m3_second_ff[i];
               push_data[96 + 32*i +: 32] = pval;
            end
            default: begin
               push_data[32*i +: 32]      = m3_second_ff[i];
               push_data[96 + 32*i +: 32] = '0;
            end
         endcase
      end
   end

   // ---------------- output register and skid ----------------
   logic                 rsp_vld_ff, skid_vld_ff;
   logic [SLC_RSP_W-1:0] rsp_data_ff, skid_data_ff;
   logic [1:0]           rsp_user_ff, skid_user_ff;
   logic                 push;

   assign push = m3_vld_ff && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_tready) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (rsp_vld_ff && !rsp_tready) begin
            skid_vld_ff <= 1'b1;
         end else begin
            rsp_vld_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_tready) begin
            rsp_data_ff <= skid_data_ff;
            rsp_user_ff <= skid_user_ff;
         end
      end else if (push) begin
         if (rsp_vld_ff && !rsp_tready) begin
            skid_data_ff <= push_data;
            skid_user_ff <= m3_act_ff;
         end else begin
            rsp_data_ff <= push_data;
            rsp_user_ff <= m3_act_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`include "spring_length_constraint_macros.svh"

   `SLC_ASSERT_IMP(a_skid_needs_rsp, skid_vld_ff, rsp_vld_ff, "skid full with empty output")
   `SLC_ASSERT_IMP(a_skid_on_stall, $rose(skid_vld_ff), $past(rsp_vld_ff && !rsp_tready), "skid loaded without stall")
   `SLC_ASSERT_IMP(a_none_no_pull, rsp_vld_ff && rsp_user_ff == ACT_NONE, rsp_data_ff[191:96] == '0, "pull on idle spring")
   `SLC_ASSERT_IMP(a_clamp_no_pull, rsp_vld_ff && (rsp_user_ff == ACT_STRETCH || rsp_user_ff == ACT_SQUEEZE), rsp_data_ff[191:96] == '0, "pull on clamped spring")
   `SLC_ASSERT_NXT(a_skid_drains, skid_vld_ff && rsp_tready, !skid_vld_ff && rsp_vld_ff, "skid not drained")

endmodule

// ===== rtl/core/slc_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_sqrt_cell
// One restoring square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module slc_sqrt_cell
   import slc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   up_vld,
   input  logic [SLC_SUM_W-1:0]   up_rad,
   input  logic [SLC_REM_W-1:0]   up_rem,
   input  logic [SLC_LEN_W-1:0]   up_root,
   input  slc_pay_type            up_pay,
   output logic                   dn_vld,
   output logic [SLC_SUM_W-1:0]   dn_rad,
   output logic [SLC_REM_W-1:0]   dn_rem,
   output logic [SLC_LEN_W-1:0]   dn_root,
   output slc_pay_type            dn_pay
);

   logic                 vld_ff;
   logic [SLC_SUM_W-1:0] rad_ff, rad_in;
   logic [SLC_REM_W-1:0] rem_ff, rem_in;
   logic [SLC_LEN_W-1:0] root_ff, root_in;
   slc_pay_type          pay_ff;
   logic [SLC_REM_W-1:0] shifted, trial;

   always_comb begin
      shifted = {up_rem[SLC_REM_W-3:0], up_rad[SLC_SUM_W-1 -: 2]};
      trial   = {1'b0, up_root, 2'b01};
      rad_in  = {up_rad[SLC_SUM_W-3:0], 2'b00};
      if (shifted >= trial) begin
         rem_in  = shifted - trial;
         root_in = {up_root[SLC_LEN_W-2:0], 1'b1};
      end else begin
         rem_in  = shifted;
         root_in = {up_root[SLC_LEN_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         pay_ff  <= up_pay;
      end
   end

   assign dn_vld  = vld_ff;
   assign dn_rad  = rad_ff;
   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_pay  = pay_ff;

endmodule

// ===== rtl/core/slc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_div_cell
// One restoring division step for the three direction lanes, shared divisor.
// ----------------------------------------------------------------------------
module slc_div_cell
   import slc_pkg::*;
#(
   parameter int QW = SLC_FRACTION_BITS + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        up_vld,
   input  logic [2:0][SLC_DREM_W-1:0]  up_rem,
   input  logic [2:0][QW-1:0]          up_quo,
   input  logic [SLC_LEN_W-1:0]        up_len,
   input  slc_pay_type                 up_pay,
   output logic                        dn_vld,
   output logic [2:0][SLC_DREM_W-1:0]  dn_rem,
   output logic [2:0][QW-1:0]          dn_quo,
   output logic [SLC_LEN_W-1:0]        dn_len,
   output slc_pay_type                 dn_pay
);

   logic                       vld_ff;
   logic [2:0][SLC_DREM_W-1:0] rem_ff, rem_in;
   logic [2:0][QW-1:0]         quo_ff, quo_in;
   logic [SLC_LEN_W-1:0]       len_ff;
   slc_pay_type                pay_ff;
   logic [SLC_DREM_W-1:0]      diff;
   logic                       take;

   always_comb begin
      rem_in = '0;
      quo_in = '0;
      diff   = '0;
      take   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         take = up_rem[i] >= {1'b0, up_len};
         diff = up_rem[i] - {1'b0, up_len};
         // remainder stays below the divisor, so the top bit drops out
         if (take) begin
            rem_in[i] = {diff[SLC_DREM_W-2:0], 1'b0};
         end else begin
            rem_in[i] = {up_rem[i][SLC_DREM_W-2:0], 1'b0};
         end
         quo_in[i] = {up_quo[i][QW-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         len_ff <= up_len;
         pay_ff <= up_pay;
      end
   end

   assign dn_vld = vld_ff;
   assign dn_rem = rem_ff;
   assign dn_quo = quo_ff;
   assign dn_len = len_ff;
   assign dn_pay = pay_ff;

endmodule
